// ===== sv/wbog_pkg.sv =====
// ----------------------------------------------------------------------------
// wbog_pkg: shared types and constants
// Command/status structs, register indexes, copy path codes and routing.
// ----------------------------------------------------------------------------
`default_nettype none

package wbog_pkg;

  localparam int unsigned BW    = 48;  // counter / bandwidth width
  localparam int unsigned DVD_W = 58;  // divider dividend width
  localparam int unsigned DVS_W = 32;  // divider divisor width

  localparam logic [BW-1:0] MASK48 = {BW{1'b1}};

  // copy path codes
  localparam logic [2:0] MODE_MEMCPY = 3'd0;
  localparam logic [2:0] MODE_DMA    = 3'd1;
  localparam logic [2:0] MODE_USER   = 3'd3;
  localparam logic [2:0] MODE_SEM    = 3'd4;

  // register indexes
  localparam logic [2:0] REG_ACCT   = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_MAXBW  = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_PIN    = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;
  localparam logic [2:0] REG_MINSZ  = 3'd6;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic capture;    // register the accepted request
    logic walk_clr;   // clear sum / active count / walk index
    logic walk_en;    // read next counter entry
    logic prep;       // register products and elapsed time
    logic div_start;
    logic div_sel;    // 0 quota share, 1 bandwidth
    logic share_ld;
    logic bw_ld;
    logic close_fin;  // commit period close
    logic rd;         // read requester counter
    logic upd;        // count write and decide
    logic plain;      // tick or unaccounted write
    logic out_ld;
  } wbog_cmd_t;

  typedef struct packed {
    logic in_plain;   // incoming request is a tick or accounting is off
    logic in_past;    // clock is past the period end
    logic walk_last;
    logic div_done;
    logic out_free;
  } wbog_sts_t;

  typedef struct packed {
    logic [2:0] path;
    logic       pinned;
  } wbog_route_t;

  function automatic wbog_route_t wbog_route(logic [2:0] cm, logic short_len,
                                             logic off, logic acc, logic pin);
    wbog_route_t r;
    logic [2:0]  m;
    m = (cm > MODE_SEM) ? MODE_USER : cm;
    if (short_len || !off) m = MODE_USER;
    r.pinned = (m != MODE_USER) && (m != MODE_SEM) && acc && pin;
    if (m == MODE_DMA && !r.pinned) m = MODE_MEMCPY;
    r.path = m;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wbog_if.sv =====
// ----------------------------------------------------------------------------
// wbog_if: channel interfaces
// Request, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbog_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  requester;
  logic [31:0] length;
  logic        src_accessible;
  modport source (output valid, cmd, requester, length, src_accessible, input ready);
  modport sink   (input valid, cmd, requester, length, src_accessible, output ready);
endinterface

interface wbog_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  path;
  logic        offload;
  logic        pinned_source;
  logic        period_closed;
  logic        on_cpu_mode;
  logic [47:0] period_bytes;
  logic [47:0] bandwidth;
  modport source (output valid, path, offload, pinned_source, period_closed, on_cpu_mode,
                  period_bytes, bandwidth, input ready);
  modport sink   (input valid, path, offload, pinned_source, period_closed, on_cpu_mode,
                  period_bytes, bandwidth, output ready);
endinterface

interface wbog_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/write_bandwidth_offload_governor_top.sv =====
// ----------------------------------------------------------------------------
// write_bandwidth_offload_governor_top: write path governor
// Picks the copy path of each write request from per-requester accounting.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  in_i    | in  | cmd, requester, length, src_accessible
//  out_o   | out | path, offload, pinned_source, period_closed, on_cpu_mode,
//          |     | period_bytes, bandwidth
//  cfg_i   | in  | index, data (register write, always ready)
//
//  Tick or unaccounted write: one plain step (ST_PLAIN), then the result is
//  registered into out_o from ST_DONE.
//  Accounted write without close: counter memory read (ST_RD), update
//  (ST_UPD), then the result is registered into out_o from ST_DONE.
//  Period close comes before the read: counter walk through the memory
//  port and two 58-step passes of the shared serial divider.
//  One request in flight; in_i.ready is low until its result enters out_o.
//  A stalled result holds out_o and the next result waits in the sequencer.
//  Reset is asynchronous and clears accounting state; counter memory is not reset (nz_q marks entries as zero).
// ----------------------------------------------------------------------------
`default_nettype none

module write_bandwidth_offload_governor_top
  import wbog_pkg::*;
#(
  parameter int unsigned NUM_CPUS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wbog_in_if.sink   in_i,
  wbog_out_if.source out_o,
  wbog_cfg_if.sink  cfg_i
);

  wbog_cmd_t cmd;   // sequencer -> datapath commands
  wbog_sts_t sts;   // datapath status back to sequencer

  // request acceptance is owned by the sequencer
  wbog_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // all storage and arithmetic
  wbog_dp #(.NUM_CPUS(NUM_CPUS)) u_dp (
    .clk_i, .rst_ni,
    .in_i, .out_o, .cfg_i,
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

`default_nettype wire

// ===== sv/wbog_div.sv =====
// ----------------------------------------------------------------------------
// wbog_div: iterative restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wbog_div
  import wbog_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W:0]   rem_q, rem_sh, diff;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DVS_W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== sv/wbog_ctrl.sv =====
// ----------------------------------------------------------------------------
// wbog_ctrl: sequencing state machine
// Steps a request through the plain path or period close and counting, then result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wbog_ctrl
  import wbog_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire wbog_sts_t sts_i,
  output wbog_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PLAIN, ST_WALK, ST_WEND, ST_PREP, ST_DIVS, ST_DIVSW,
    ST_DIVB, ST_DIVBW, ST_CLOSE, ST_RD, ST_UPD, ST_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.walk_clr = 1'b1;
          if (sts_i.in_plain)     state_d = ST_PLAIN;
          else if (sts_i.in_past) state_d = ST_WALK;
          else                    state_d = ST_RD;
        end
      end
      ST_PLAIN: begin
        cmd_o.plain = 1'b1;
        state_d     = ST_DONE;
      end
      ST_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_last) state_d = ST_WEND;
      end
      ST_WEND: state_d = ST_PREP;
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVSW;
      end
      ST_DIVSW: begin
        if (sts_i.div_done) begin
          cmd_o.share_ld = 1'b1;
          state_d        = ST_DIVB;
        end
      end
      ST_DIVB: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = ST_DIVBW;
      end
      ST_DIVBW: begin
        if (sts_i.div_done) begin
          cmd_o.bw_ld = 1'b1;
          state_d     = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd_o.close_fin = 1'b1;
        state_d         = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_DIVSW || state_q == ST_DIVBW))
    else $error("divider finished outside a wait state");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while still busy");
  a_upd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd |=> (state_q == ST_DONE))
    else $error("count step not followed by hand-off");
`endif

endmodule

`default_nettype wire

// ===== sv/wbog_dp.sv =====
// ----------------------------------------------------------------------------
// wbog_dp: governor datapath
// Registers, byte counter memory, period close arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbog_dp
  import wbog_pkg::*;
#(
  parameter int unsigned NUM_CPUS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  wbog_in_if.sink        in_i,
  wbog_out_if.source     out_o,
  wbog_cfg_if.sink       cfg_i,
  input  wire wbog_cmd_t cmd_i,
  output wbog_sts_t      sts_o
);

  localparam int unsigned IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned AW = $clog2(NUM_CPUS + 1);

  // configuration
  logic        acct_q, pin_q;
  logic [15:0] period_q, maxbw_q, thresh_q;
  logic [2:0]  mode_q;
  logic [31:0] minsz_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acct_q   <= 1'b0;
      period_q <= 16'd1000;
      maxbw_q  <= 16'd800;
      thresh_q <= 16'd500;
      pin_q    <= 1'b1;
      mode_q   <= MODE_USER;
      minsz_q  <= 32'd4096;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ACCT:   acct_q   <= cfg_i.data[0];
        REG_PERIOD: period_q <= cfg_i.data[15:0];
        REG_MAXBW:  maxbw_q  <= cfg_i.data[15:0];
        REG_THRESH: thresh_q <= cfg_i.data[15:0];
        REG_PIN:    pin_q    <= cfg_i.data[0];
        REG_MODE:   mode_q   <= cfg_i.data[2:0];
        REG_MINSZ:  minsz_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // captured request
  logic        cmd_q, acc_q;
  logic [2:0]  req_q;
  logic [31:0] len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_i.cmd;
      req_q <= in_i.requester;
      len_q <= in_i.length;
      acc_q <= in_i.src_accessible;
    end
  end

  logic          in_range;
  logic [IW-1:0] req_idx;
  assign in_range = 32'(req_q) < NUM_CPUS;
  assign req_idx  = IW'(req_q);

  // state
  logic [31:0]         now_q, start_q, end_q;
  logic                on_cpu_q, closed_q;
  logic [BW-1:0]       lbytes_q, lbw_q, share_q;
  logic [NUM_CPUS-1:0] nz_q, qact_q;

  // counter memory
  logic [BW-1:0] mem_q [NUM_CPUS];
  logic [BW-1:0] rd_q;
  logic          rd_nz_q, pend_q;
  logic [IW-1:0] walk_q, rd_addr;

  // counting
  logic [BW:0]    cnt_add;
  logic [BW-1:0]  cnt_cur, cnt_new, total, lim;
  logic           off_w;

  assign rd_addr = cmd_i.rd ? req_idx : walk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd || cmd_i.walk_en) rd_q <= mem_q[rd_addr];
    if (cmd_i.upd && in_range)     mem_q[req_idx] <= cnt_new;
  end

  // walk accumulators
  logic [BW-1:0] sum_q;
  logic [AW-1:0] act_q;
  logic [BW:0]   sum_add;
  assign sum_add = {1'b0, sum_q} + {1'b0, (rd_nz_q ? rd_q : '0)};

  assign cnt_cur = nz_q[req_idx] ? rd_q : '0;
  assign cnt_add = {1'b0, cnt_cur} + (BW+1)'(len_q);
  assign cnt_new = cnt_add[BW] ? MASK48 : cnt_add[BW-1:0];
  assign total   = in_range ? cnt_new : BW'(len_q);
  assign lim     = (in_range && qact_q[req_idx]) ? share_q : '0;
  assign off_w   = !on_cpu_q && (total > lim);

  // close arithmetic
  logic [31:0]      prod_q, elap_q, dvs_share_q, elap_d;
  logic [DVD_W-1:0] sum1k_q;
  logic [BW-1:0]    bw_new_q;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [DVD_W-1:0] quo;

  assign elap_d = now_q - start_q;
  assign dvd    = cmd_i.div_sel ? sum1k_q : DVD_W'({prod_q, 20'b0});
  assign dvs    = cmd_i.div_sel ? elap_q : dvs_share_q;

  wbog_div u_div (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      prod_q      <= 32'(maxbw_q) * 32'(period_q);
      sum1k_q     <= DVD_W'(sum_q) * DVD_W'(10'd1000);
      dvs_share_q <= 32'(32'(act_q) * 32'd1000);
      elap_q      <= (elap_d == 32'd0) ? 32'd1 : elap_d;
    end
    if (cmd_i.bw_ld) bw_new_q <= (|quo[DVD_W-1:BW]) ? MASK48 : quo[BW-1:0];
  end

  // result
  wbog_route_t rt, res_q;
  logic        res_off_q;
  logic        rt_off;
  assign rt_off = cmd_i.upd ? off_w : 1'b1;
  assign rt     = wbog_route(mode_q, len_q < minsz_q, rt_off, acc_q, pin_q);

  logic out_valid_q;
  assign sts_o.out_free  = !out_valid_q || out_o.ready;
  assign sts_o.in_plain  = (in_i.cmd == CMD_TICK) || !acct_q;
  assign sts_o.in_past   = (end_q - now_q) >> 31 != 32'd0;
  assign sts_o.walk_last = (32'(walk_q) == NUM_CPUS - 1);
  assign sts_o.div_done  = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.plain) begin
      res_q     <= (cmd_q == CMD_TICK) ? '0 : rt;
      res_off_q <= (cmd_q != CMD_TICK);
    end else if (cmd_i.upd) begin
      res_q     <= rt;
      res_off_q <= off_w;
    end
    if (cmd_i.out_ld) begin
      out_o.path          <= res_q.path;
      out_o.pinned_source <= res_q.pinned;
      out_o.offload       <= res_off_q;
      out_o.period_closed <= closed_q;
      out_o.on_cpu_mode   <= on_cpu_q;
      out_o.period_bytes  <= lbytes_q;
      out_o.bandwidth     <= lbw_q;
    end
  end

  assign out_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      now_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
      on_cpu_q    <= 1'b0;
      closed_q    <= 1'b0;
      lbytes_q    <= '0;
      lbw_q       <= '0;
      share_q     <= '0;
      nz_q        <= '0;
      qact_q      <= '0;
      walk_q      <= '0;
      sum_q       <= '0;
      act_q       <= '0;
      pend_q      <= 1'b0;
      rd_nz_q     <= 1'b0;
    end else begin
      if (cmd_i.out_ld)     out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      pend_q <= cmd_i.walk_en;
      if (cmd_i.walk_en) rd_nz_q <= nz_q[walk_q];
      if (cmd_i.capture) closed_q <= 1'b0;
      if (cmd_i.walk_clr) begin
        walk_q <= '0;
        sum_q  <= '0;
        act_q  <= '0;
      end else begin
        if (cmd_i.walk_en) walk_q <= walk_q + 1'b1;
        if (pend_q) begin
          sum_q <= sum_add[BW] ? MASK48 : sum_add[BW-1:0];
          act_q <= act_q + AW'(rd_nz_q);
        end
      end
      if (cmd_i.plain && cmd_q == CMD_TICK) now_q <= now_q + 32'd1;
      if (cmd_i.share_ld) share_q <= (act_q == '0) ? '0 : quo[BW-1:0];
      if (cmd_i.close_fin) begin
        closed_q <= 1'b1;
        qact_q   <= nz_q;
        nz_q     <= '0;
        lbytes_q <= sum_q;
        lbw_q    <= bw_new_q;
        on_cpu_q <= bw_new_q[BW-1:20] < 28'(thresh_q);
        start_q  <= now_q;
        end_q    <= now_q + 32'(period_q);
      end
      if (cmd_i.upd && in_range && cnt_new != '0) nz_q[req_idx] <= 1'b1;
    end
  end

endmodule

`default_nettype wire
